[design/spf_pkg.sv]
// shared widths, codes and types of the segment prefetch scheduler
package spf_pkg;

    localparam int MODE_W     = 2;
    localparam int SEG_IDX_W  = 8;
    localparam int DUR_IN_W   = 16;
    localparam int POS_W      = 9;
    localparam int COUNT_W    = 9;
    localparam int LEVEL_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef logic [MODE_W-1:0]     mode_t;
    typedef logic [SEG_IDX_W-1:0]  seg_idx_t;
    typedef logic [DUR_IN_W-1:0]   dur_in_t;
    typedef logic [POS_W-1:0]      pos_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [LEVEL_W-1:0]    level_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    localparam mode_t MODE_TICK       = 2'd0;
    localparam mode_t MODE_LOAD       = 2'd1;
    localparam mode_t MODE_SET_CACHED = 2'd2;
    localparam mode_t MODE_FETCH_DONE = 2'd3;

    localparam cfg_idx_t REG_EMERGENCY = 2'd0;
    localparam cfg_idx_t REG_SAFE      = 2'd1;
    localparam cfg_idx_t REG_SEG_COUNT = 2'd2;

    localparam level_t LEVEL_MAX = 24'hFFFFFF;

endpackage

[design/spf_in_if.sv]
// input item channel of the segment prefetch scheduler
interface spf_in_if;
    logic              valid;
    logic              ready;
    spf_pkg::mode_t    mode;
    spf_pkg::seg_idx_t segment_index;
    spf_pkg::dur_in_t  duration_ms;
    logic              cached_value;
    spf_pkg::pos_t     play_position;

    modport source (output valid, mode, segment_index, duration_ms, cached_value,
                    play_position, input ready);
    modport sink   (input valid, mode, segment_index, duration_ms, cached_value,
                    play_position, output ready);
endinterface

[design/spf_out_if.sv]
// result item channel of the segment prefetch scheduler
interface spf_out_if;
    logic              valid;
    logic              ready;
    logic              action;
    spf_pkg::seg_idx_t fetch_index;
    spf_pkg::level_t   buffered_ms;
    logic              pulling;

    modport source (output valid, action, fetch_index, buffered_ms, pulling, input ready);
    modport sink   (input valid, action, fetch_index, buffered_ms, pulling, output ready);
endinterface

[design/spf_cfg_if.sv]
// register write channel of the segment prefetch scheduler
interface spf_cfg_if;
    logic               valid;
    logic               ready;
    spf_pkg::cfg_idx_t  index;
    spf_pkg::cfg_data_t data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[design/segment_prefetch_scheduler_top.sv]
// segment prefetch scheduler: duration/cached tables, buffer walk and pull decision
//
// channels: req carries one item (tick, load duration, set cached bit, fetch finished),
// rsp returns exactly one result per item, cfg writes the emergency level, the safe
// level and the segment count at any time (cfg.ready is always high).
// a load, set or fetch-finished item goes through ST_FIN into the output register, and
// req.ready returns in the same cycle that its result appears on rsp.
// a tick walks the segment memories one entry per cycle from the play position until
// the first uncached segment or the end of the playlist, then passes ST_DECIDE and ST_FIN
// and loads its result; the single read port of the segment memories sets the walk rate.
// req.ready is high only while no item is in work.
// after reset the cached bits are cleared by a pass over all SEGMENTS entries; req.ready
// stays low during it. levels, count, pull flag and in-flight record reset to zero.
// a result sits in an output register until rsp.ready; while it waits the block can
// take the next item, and a finished result waits in its last state until the output
// register frees.
module segment_prefetch_scheduler_top #(
    parameter int SEGMENTS      = 256,
    parameter int DURATION_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    spf_in_if.sink     req,
    spf_out_if.source  rsp,
    spf_cfg_if.sink    cfg
);

    localparam int ADDR_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int ACC_W  = ((DURATION_BITS > spf_pkg::LEVEL_W) ? DURATION_BITS
                                                                 : spf_pkg::LEVEL_W) + 1;
    localparam logic [16:0]       SEG_LIM   = 17'(SEGMENTS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SEGMENTS - 1);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_FIN    = 3'd4;

    // control state
    logic [2:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       clr_reg, clr_next;
    spf_pkg::level_t         emerg_reg, emerg_next;
    spf_pkg::level_t         safe_reg, safe_next;
    spf_pkg::count_t         seg_use_reg, seg_use_next;
    spf_pkg::count_t         cnt_reg, cnt_next;
    spf_pkg::pos_t           scan_reg, scan_next;
    spf_pkg::seg_idx_t       lat_reg, lat_next;
    logic                    pend_reg, pend_next;
    logic                    found_reg, found_next;
    logic                    passed_reg, passed_next;
    logic                    pull_flag_reg, pull_flag_next;
    logic                    infl_v_reg, infl_v_next;
    spf_pkg::seg_idx_t       infl_idx_reg, infl_idx_next;
    logic                    out_v_reg, out_v_next;

    // payload
    spf_pkg::level_t         sum_reg, sum_next;
    spf_pkg::seg_idx_t       stop_reg, stop_next;
    logic                    res_act_reg, res_act_next;
    spf_pkg::seg_idx_t       res_idx_reg, res_idx_next;
    spf_pkg::level_t         res_buf_reg, res_buf_next;
    logic                    out_act_reg, out_act_next;
    spf_pkg::seg_idx_t       out_idx_reg, out_idx_next;
    spf_pkg::level_t         out_buf_reg, out_buf_next;
    logic                    out_pull_reg, out_pull_next;

    // segment memories
    logic [DURATION_BITS-1:0] dur_mem [SEGMENTS];
    logic                     cach_mem [SEGMENTS];
    logic [DURATION_BITS-1:0] dur_q;
    logic                     cach_q;

    logic                     acc;
    logic                     in_range;
    logic                     dur_we;
    logic                     cach_we;
    logic                     cach_wd;
    logic [ADDR_W-1:0]        wr_addr;
    logic [ADDR_W-1:0]        rd_addr;
    logic [31:0]              dur_ext;
    logic [DURATION_BITS-1:0] dur_wd;
    spf_pkg::count_t          cnt_lim;
    logic                     issue;
    logic                     hit_end;
    logic                     scan_done;
    logic [ACC_W-1:0]         acc_sum;
    spf_pkg::level_t          sum_add;
    logic                     pull;
    logic                     out_load;

    assign acc       = req.valid && req.ready;
    assign in_range  = {9'd0, req.segment_index} < SEG_LIM;
    assign dur_we    = acc && (req.mode == spf_pkg::MODE_LOAD) && in_range;
    assign cach_we   = (state_reg == ST_CLEAR)
                    || (acc && (req.mode == spf_pkg::MODE_SET_CACHED) && in_range);
    assign wr_addr   = (state_reg == ST_CLEAR) ? clr_reg : ADDR_W'(req.segment_index);
    assign cach_wd   = (state_reg == ST_CLEAR) ? 1'b0 : req.cached_value;
    assign dur_ext   = 32'(req.duration_ms);
    assign dur_wd    = dur_ext[DURATION_BITS-1:0];
    assign rd_addr   = ADDR_W'(scan_reg);

    assign cnt_lim   = ({8'd0, seg_use_reg} > SEG_LIM) ? SEG_LIM[8:0] : seg_use_reg;

    // one entry issued per cycle, its data checked the cycle after
    assign issue     = scan_reg < cnt_reg;
    assign hit_end   = pend_reg && !cach_q;
    assign scan_done = hit_end || !issue;
    assign acc_sum   = ACC_W'(sum_reg) + ACC_W'(dur_q);
    assign sum_add   = (acc_sum > ACC_W'(spf_pkg::LEVEL_MAX)) ? spf_pkg::LEVEL_MAX
                                                              : acc_sum[spf_pkg::LEVEL_W-1:0];

    assign pull      = (sum_reg < emerg_reg) || ((sum_reg < safe_reg) && pull_flag_reg);
    assign out_load  = (state_reg == ST_FIN) && (!out_v_reg || rsp.ready);

    assign req.ready       = (state_reg == ST_IDLE);
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_v_reg;
    assign rsp.action      = out_act_reg;
    assign rsp.fetch_index = out_idx_reg;
    assign rsp.buffered_ms = out_buf_reg;
    assign rsp.pulling     = out_pull_reg;

    always_ff @(posedge clk)
    begin
        if (dur_we)
        begin
            dur_mem[wr_addr] <= dur_wd;
        end
        if (cach_we)
        begin
            cach_mem[wr_addr] <= cach_wd;
        end
        dur_q  <= dur_mem[rd_addr];
        cach_q <= cach_mem[rd_addr];
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        emerg_next     = emerg_reg;
        safe_next      = safe_reg;
        seg_use_next   = seg_use_reg;
        cnt_next       = cnt_reg;
        scan_next      = scan_reg;
        lat_next       = lat_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        passed_next    = passed_reg;
        pull_flag_next = pull_flag_reg;
        infl_v_next    = infl_v_reg;
        infl_idx_next  = infl_idx_reg;
        out_v_next     = out_v_reg;
        sum_next       = sum_reg;
        stop_next      = stop_reg;
        res_act_next   = res_act_reg;
        res_idx_next   = res_idx_reg;
        res_buf_next   = res_buf_reg;
        out_act_next   = out_act_reg;
        out_idx_next   = out_idx_reg;
        out_buf_next   = out_buf_reg;
        out_pull_next  = out_pull_reg;

        if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                spf_pkg::REG_EMERGENCY: emerg_next   = cfg.data;
                spf_pkg::REG_SAFE:      safe_next    = cfg.data;
                spf_pkg::REG_SEG_COUNT: seg_use_next = cfg.data[8:0];
                default:                ;
            endcase
        end

        if (rsp.valid && rsp.ready)
        begin
            out_v_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (acc)
                begin
                    res_act_next = 1'b0;
                    res_idx_next = '0;
                    res_buf_next = '0;
                    state_next   = ST_FIN;
                    case (req.mode)
                        spf_pkg::MODE_TICK:
                        begin
                            // empty playlist leaves everything as it is
                            if (cnt_lim != '0)
                            begin
                                cnt_next    = cnt_lim;
                                scan_next   = req.play_position;
                                pend_next   = 1'b0;
                                sum_next    = '0;
                                found_next  = 1'b0;
                                passed_next = 1'b0;
                                state_next  = ST_SCAN;
                            end
                        end
                        spf_pkg::MODE_FETCH_DONE: infl_v_next = 1'b0;
                        default:                  ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (pend_reg && cach_q)
                begin
                    sum_next    = sum_add;
                    passed_next = 1'b1;
                end
                if (hit_end)
                begin
                    found_next = 1'b1;
                    stop_next  = lat_reg;
                end
                if (scan_done)
                begin
                    pend_next  = 1'b0;
                    state_next = ST_DECIDE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    lat_next  = scan_reg[7:0];
                    pend_next = 1'b1;
                end
            end
            ST_DECIDE:
            begin
                res_act_next = 1'b0;
                res_idx_next = '0;
                res_buf_next = sum_reg;
                if (!pull || !found_reg)
                begin
                    pull_flag_next = 1'b0;
                end
                else if (infl_v_reg && (infl_idx_reg == stop_reg))
                begin
                    // same fetch already in flight: flag only picks up cached ones passed
                    if (passed_reg)
                    begin
                        pull_flag_next = 1'b1;
                    end
                end
                else
                begin
                    infl_v_next    = 1'b1;
                    infl_idx_next  = stop_reg;
                    pull_flag_next = 1'b1;
                    res_act_next   = 1'b1;
                    res_idx_next   = stop_reg;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    out_v_next    = 1'b1;
                    out_act_next  = res_act_reg;
                    out_idx_next  = res_idx_reg;
                    out_buf_next  = res_buf_reg;
                    out_pull_next = pull_flag_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            emerg_reg     <= '0;
            safe_reg      <= '0;
            seg_use_reg   <= '0;
            cnt_reg       <= '0;
            scan_reg      <= '0;
            lat_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            passed_reg    <= 1'b0;
            pull_flag_reg <= 1'b0;
            infl_v_reg    <= 1'b0;
            infl_idx_reg  <= '0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            emerg_reg     <= emerg_next;
            safe_reg      <= safe_next;
            seg_use_reg   <= seg_use_next;
            cnt_reg       <= cnt_next;
            scan_reg      <= scan_next;
            lat_reg       <= lat_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            passed_reg    <= passed_next;
            pull_flag_reg <= pull_flag_next;
            infl_v_reg    <= infl_v_next;
            infl_idx_reg  <= infl_idx_next;
            out_v_reg     <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg      <= sum_next;
        stop_reg     <= stop_next;
        res_act_reg  <= res_act_next;
        res_idx_reg  <= res_idx_next;
        res_buf_reg  <= res_buf_next;
        out_act_reg  <= out_act_next;
        out_idx_reg  <= out_idx_next;
        out_buf_reg  <= out_buf_next;
        out_pull_reg <= out_pull_next;
    end

    // a fetch result always matches the in-flight record it created
    a_fetch_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && res_act_reg) |=> (infl_v_reg && (infl_idx_reg == rsp.fetch_index)))
        else $error("fetch result without matching in-flight record");

    a_fetch_pulls: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.action) |-> rsp.pulling)
        else $error("fetch given while pull flag is clear");

    a_no_fetch_zero_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.action) |-> (rsp.fetch_index == '0))
        else $error("fetch index nonzero without a fetch");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ({1'b0, lat_reg} < cnt_reg))
        else $error("walk checked an entry beyond the playlist");

endmodule
